// ----- design/vector_line_stroke_generator_assert.svh -----
// Assertion macros shared by the stroke generator RTL.
`ifndef VECTOR_LINE_STROKE_GENERATOR_ASSERT_SVH
`define VECTOR_LINE_STROKE_GENERATOR_ASSERT_SVH

// Condition that holds at every clock edge outside reset.
`define VLSG_CHECK(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("vlsg check failed");

// Same-cycle implication.
`define VLSG_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vlsg implication failed");

// Next-cycle implication.
`define VLSG_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vlsg next-cycle check failed");

`endif

// ----- design/vlsg_pkg.sv -----
// Shared constants, types and code conversion for the vector line stroke generator.
`timescale 1ns / 1ps

package vlsg_pkg;

    localparam int COORD_W = 16;
    localparam int DELTA_W = 16;
    localparam int CODE_W  = 8;

    localparam logic [CODE_W-1:0] CODE_CENTER = 8'd128;

    localparam logic CMD_LINE  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    typedef struct packed {
        logic beam;
        logic last;
    } t_beam_flags;

    // 128 + c/256 with the quotient truncated toward zero
    function automatic logic [CODE_W-1:0] to_code(input logic signed [COORD_W-1:0] c);
        logic [CODE_W-1:0] hi;
        logic              rnd;
        hi  = c[COORD_W-1:COORD_W-CODE_W];
        rnd = c[COORD_W-1] && (c[COORD_W-CODE_W-1:0] != '0);
        return hi + {{(CODE_W-1){1'b0}}, rnd} + CODE_CENTER;
    endfunction

endpackage

// ----- design/vector_line_stroke_generator.sv -----
// Vector line stroke generator: turns line and point requests into converter codes.
//
//   channel   dir  handshake                  payload
//   s_axis    in   i_s_axis_tvalid/o_tready   tuser=cmd, tdata=x_start,y_start,x_end,y_end
//   m_axis    out  o_m_axis_tvalid/i_tready   tdata=dac_x,dac_y, tuser=beam_on, tlast=last
//
// A line request yields LINE_STEPS+2 results, a point request two; one result leaves per
// cycle while the output does not stall. A request passes the input buffer, the sequencer
// and five stages before its first result leaves.
// Reset (i_rst_n low, synchronous) clears all valid bits; payload registers are not reset.
// An output stall freezes the whole stage chain; the input buffer still takes one request.
`timescale 1ns / 1ps
`include "vector_line_stroke_generator_assert.svh"

module vector_line_stroke_generator
    import vlsg_pkg::*;
#(
    parameter int LINE_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // x_start, y_start, x_end, y_end (low to high)
    input  logic        i_s_axis_tuser,   // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // dac_x, dac_y (low to high)
    output logic        o_m_axis_tuser,   // beam_on
    output logic        o_m_axis_tlast    // last
);

    localparam int IDX_W   = $clog2(LINE_STEPS + 1);
    localparam int CNT_W   = $clog2(LINE_STEPS + 2);
    localparam int STEP_LG = $clog2(LINE_STEPS);
    localparam int PROD_W  = DELTA_W + IDX_W;
    localparam int SHIFT   = PROD_W + STEP_LG;
    localparam int RECIP_W = PROD_W + 1;
    localparam int MUL_W   = PROD_W + RECIP_W;
    // ceil(2^SHIFT / LINE_STEPS): exact floor division for every product below 2^PROD_W
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(LINE_STEPS) - 64'd1) / 64'(LINE_STEPS));
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(LINE_STEPS + 1);

    // input buffer
    logic                       r_in_vld;
    logic                       r_in_cmd;
    logic signed [COORD_W-1:0]  r_in_xs, r_in_ys, r_in_xe, r_in_ye;

    // sequencer
    logic                       r_sq_vld;
    logic                       r_sq_cmd;
    logic [CNT_W-1:0]           r_sq_cnt;
    logic signed [COORD_W-1:0]  r_sq_xs, r_sq_ys;
    logic [DELTA_W-1:0]         r_sq_adx, r_sq_ady;
    logic                       r_sq_negx, r_sq_negy;

    // stages
    logic                       r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    t_beam_flags                r1_flg, r2_flg, r3_flg, r4_flg, r5_flg;
    logic [IDX_W-1:0]           r1_idx;
    logic signed [COORD_W-1:0]  r1_xs, r1_ys, r2_xs, r2_ys, r3_xs, r3_ys;
    logic [DELTA_W-1:0]         r1_adx, r1_ady;
    logic                       r1_negx, r1_negy, r2_negx, r2_negy, r3_negx, r3_negy;
    logic [PROD_W-1:0]          r2_px, r2_py;
    logic [DELTA_W-1:0]         r3_qx, r3_qy;
    logic signed [COORD_W-1:0]  r4_x, r4_y;
    logic [CODE_W-1:0]          r5_dacx, r5_dacy;

    logic                       w_en;
    logic                       w_sq_done;
    logic                       w_sq_take;
    logic                       w_in_acc;
    logic [IDX_W-1:0]           w_tok_idx;
    t_beam_flags                w_tok_flg;
    logic signed [DELTA_W:0]    w_dx, w_dy;
    logic [MUL_W-1:0]           w_mx, w_my;
    logic signed [COORD_W+1:0]  w_offx, w_offy, w_sumx, w_sumy;

    assign w_en      = !r5_vld || i_m_axis_tready;
    assign w_sq_done = (r_sq_cmd == CMD_POINT) ? (r_sq_cnt == CNT_W'(1))
                                               : (r_sq_cnt == CNT_END);
    assign w_sq_take = w_en && (!r_sq_vld || w_sq_done);

    assign o_s_axis_tready = !r_in_vld || w_sq_take;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_dx = {r_in_xe[COORD_W-1], r_in_xe} - {r_in_xs[COORD_W-1], r_in_xs};
    assign w_dy = {r_in_ye[COORD_W-1], r_in_ye} - {r_in_ys[COORD_W-1], r_in_ys};

    // step index: 0 for the dark move and point dwell, LINE_STEPS lands on the end point
    always_comb begin
        if (r_sq_cmd == CMD_POINT || r_sq_cnt == '0) begin
            w_tok_idx = '0;
        end else if (r_sq_cnt == CNT_END) begin
            w_tok_idx = IDX_W'(LINE_STEPS);
        end else begin
            w_tok_idx = IDX_W'(r_sq_cnt - CNT_W'(1));
        end
        w_tok_flg.beam = (r_sq_cnt != '0);
        w_tok_flg.last = w_sq_done;
    end

    assign w_mx = MUL_W'(r2_px) * MUL_W'(RECIP);
    assign w_my = MUL_W'(r2_py) * MUL_W'(RECIP);

    assign w_offx = r3_negx ? -$signed({2'b00, r3_qx}) : $signed({2'b00, r3_qx});
    assign w_offy = r3_negy ? -$signed({2'b00, r3_qy}) : $signed({2'b00, r3_qy});
    assign w_sumx = {{2{r3_xs[COORD_W-1]}}, r3_xs} + w_offx;
    assign w_sumy = {{2{r3_ys[COORD_W-1]}}, r3_ys} + w_offy;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_sq_vld <= 1'b0;
            r_sq_cnt <= '0;
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r3_vld   <= 1'b0;
            r4_vld   <= 1'b0;
            r5_vld   <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_sq_take) begin
                r_in_vld <= 1'b0;
            end
            if (w_sq_take) begin
                r_sq_vld <= r_in_vld;
                r_sq_cnt <= '0;
            end else if (w_en && r_sq_vld) begin
                r_sq_cnt <= r_sq_cnt + CNT_W'(1);
            end
            if (w_en) begin
                r1_vld <= r_sq_vld;
                r2_vld <= r1_vld;
                r3_vld <= r2_vld;
                r4_vld <= r3_vld;
                r5_vld <= r4_vld;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_cmd <= i_s_axis_tuser;
            r_in_xs  <= i_s_axis_tdata[15:0];
            r_in_ys  <= i_s_axis_tdata[31:16];
            r_in_xe  <= i_s_axis_tdata[47:32];
            r_in_ye  <= i_s_axis_tdata[63:48];
        end
        if (w_sq_take) begin
            r_sq_cmd  <= r_in_cmd;
            r_sq_xs   <= r_in_xs;
            r_sq_ys   <= r_in_ys;
            r_sq_negx <= w_dx[DELTA_W];
            r_sq_negy <= w_dy[DELTA_W];
            r_sq_adx  <= w_dx[DELTA_W] ? DELTA_W'(-w_dx) : w_dx[DELTA_W-1:0];
            r_sq_ady  <= w_dy[DELTA_W] ? DELTA_W'(-w_dy) : w_dy[DELTA_W-1:0];
        end
        if (w_en) begin
            r1_idx  <= w_tok_idx;
            r1_flg  <= w_tok_flg;
            r1_xs   <= r_sq_xs;
            r1_ys   <= r_sq_ys;
            r1_adx  <= r_sq_adx;
            r1_ady  <= r_sq_ady;
            r1_negx <= r_sq_negx;
            r1_negy <= r_sq_negy;

            // i * |delta|
            r2_px   <= PROD_W'(r1_adx) * PROD_W'(r1_idx);
            r2_py   <= PROD_W'(r1_ady) * PROD_W'(r1_idx);
            r2_flg  <= r1_flg;
            r2_xs   <= r1_xs;
            r2_ys   <= r1_ys;
            r2_negx <= r1_negx;
            r2_negy <= r1_negy;

            // divide by LINE_STEPS through the reciprocal
            r3_qx   <= w_mx[SHIFT +: DELTA_W];
            r3_qy   <= w_my[SHIFT +: DELTA_W];
            r3_flg  <= r2_flg;
            r3_xs   <= r2_xs;
            r3_ys   <= r2_ys;
            r3_negx <= r2_negx;
            r3_negy <= r2_negy;

            // apply sign and add start; interpolated points stay inside 16 bits
            r4_x    <= w_sumx[COORD_W-1:0];
            r4_y    <= w_sumy[COORD_W-1:0];
            r4_flg  <= r3_flg;

            r5_dacx <= to_code(r4_x);
            r5_dacy <= to_code(r4_y);
            r5_flg  <= r4_flg;
        end
    end

    assign o_m_axis_tvalid = r5_vld;
    assign o_m_axis_tdata  = {r5_dacy, r5_dacx};
    assign o_m_axis_tuser  = r5_flg.beam;
    assign o_m_axis_tlast  = r5_flg.last;

    `VLSG_CHECK(a_cnt_bound, !r_sq_vld || r_sq_cnt <= CNT_END)
    `VLSG_CHECK_NOW(a_point_short, r_sq_vld && r_sq_cmd == CMD_POINT, r_sq_cnt <= CNT_W'(1))
    `VLSG_CHECK_NOW(a_last_lit, r5_vld && r5_flg.last, r5_flg.beam)
    `VLSG_CHECK_NEXT(a_stall_freeze, !w_en && r1_vld, r1_vld && $stable(r1_idx) && $stable(r1_flg))

endmodule
